[hdl/deque_pkg.sv]
// Shared types, command codes and defaults for the deque block.
package deque_pkg;

    // Default number of entries in the ring store
    localparam int DEPTH_DEFAULT = 32;

    localparam int CMD_W   = 3;
    localparam int VALUE_W = 32;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_EMPTY_QRY  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd5;

    // Command beat
    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic signed [VALUE_W-1:0] push_value;
    } cmd_beat_t;

    // Response beat
    typedef struct packed {
        logic signed [VALUE_W-1:0] out_value;
        logic                      was_empty;
        logic                      dropped;
        logic                      last;
    } rsp_beat_t;

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_EMIT
    } state_t;

endpackage

[hdl/deque_ram.sv]
// Generic single-clock RAM: one write port, one read port with registered data.
module deque_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/deque_push_pop_dump.sv]
// Top level of the bounded deque: ring store controller and response register.
//
// Bounded double-ended queue of signed 32-bit values kept in a DEPTH-entry RAM
// addressed by a front pointer and an entry count. Push front and push back write
// the RAM as they are accepted and can be taken back to back. Pop front and peek
// front read the RAM first, since the RAM read port returns registered data. A
// dump starts the first read, then sends one response beat per entry as the read
// port walks from front to back. Empty query, a dropped push and a pop, peek or
// dump on an empty queue answer straight from the response register. A command
// is only taken while the controller is idle and the response register is free
// or draining, so a stalled response side holds the command channel. Unused
// command codes are consumed with no response. The RAM needs no clearing after reset.
module deque_push_pop_dump #(
    parameter int DEPTH = deque_pkg::DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  deque_pkg::cmd_beat_t cmd_data,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output deque_pkg::rsp_beat_t rsp_data
);

    import deque_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;

    state_t           state_reg, state_next;
    logic [PTR_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic [PTR_W-1:0] dptr_reg, dptr_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_beat_t        rsp_data_reg, rsp_data_next;

    logic               cmd_accept;
    logic               rsp_free;
    logic               rsp_load;
    logic               is_empty;
    logic               is_full;
    logic [PTR_W-1:0]   front_inc;
    logic [PTR_W-1:0]   front_dec;
    logic [PTR_W-1:0]   dptr_inc;
    logic [SUM_W-1:0]   back_sum;
    logic [PTR_W-1:0]   back_slot;

    logic               ram_we;
    logic [PTR_W-1:0]   ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic               ram_re;
    logic [PTR_W-1:0]   ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    // Ring store
    deque_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Handshake
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign cmd_stall  = (state_reg != S_IDLE) || !rsp_free;
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp_data   = rsp_data_reg;

    // Pointer arithmetic, modulo DEPTH
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign front_inc = (front_reg == PTR_W'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? PTR_W'(DEPTH - 1) : front_reg - 1'b1;
    assign dptr_inc  = (dptr_reg == PTR_W'(DEPTH - 1)) ? '0 : dptr_reg + 1'b1;
    assign back_sum  = {1'b0, front_reg} + SUM_W'(count_reg);
    assign back_slot = (back_sum >= SUM_W'(DEPTH)) ? PTR_W'(back_sum - SUM_W'(DEPTH))
                                                   : back_sum[PTR_W-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept && !is_empty &&
                    (cmd_data.cmd inside {CMD_POP_FRONT, CMD_PEEK_FRONT, CMD_DUMP}))
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (rsp_free && (remain_reg == CNT_W'(1)))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath, RAM control and response load
    always_comb
    begin
        front_next    = front_reg;
        count_next    = count_reg;
        remain_next   = remain_reg;
        dptr_next     = dptr_reg;
        ram_we        = 1'b0;
        ram_waddr     = back_slot;
        ram_wdata     = cmd_data.push_value;
        ram_re        = 1'b0;
        ram_raddr     = front_reg;
        rsp_load      = 1'b0;
        rsp_data_next = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept)
                begin
                    case (cmd_data.cmd)
                        CMD_PUSH_FRONT, CMD_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                rsp_load              = 1'b1;
                                rsp_data_next.dropped = 1'b1;
                                rsp_data_next.last    = 1'b1;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                                if (cmd_data.cmd == CMD_PUSH_FRONT)
                                begin
                                    front_next = front_dec;
                                    ram_waddr  = front_dec;
                                end
                            end
                        end
                        CMD_POP_FRONT, CMD_PEEK_FRONT:
                        begin
                            if (is_empty)
                            begin
                                rsp_load                = 1'b1;
                                rsp_data_next.was_empty = 1'b1;
                                rsp_data_next.last      = 1'b1;
                            end
                            else
                            begin
                                ram_re      = 1'b1;
                                remain_next = CNT_W'(1);
                                if (cmd_data.cmd == CMD_POP_FRONT)
                                begin
                                    front_next = front_inc;
                                    count_next = count_reg - 1'b1;
                                end
                            end
                        end
                        CMD_EMPTY_QRY:
                        begin
                            rsp_load                = 1'b1;
                            rsp_data_next.out_value = is_empty ? 32'sd1 : 32'sd0;
                            rsp_data_next.last      = 1'b1;
                        end
                        CMD_DUMP:
                        begin
                            if (is_empty)
                            begin
                                rsp_load                = 1'b1;
                                rsp_data_next.was_empty = 1'b1;
                                rsp_data_next.last      = 1'b1;
                            end
                            else
                            begin
                                ram_re      = 1'b1;
                                remain_next = count_reg;
                                dptr_next   = front_inc;
                            end
                        end
                        default:
                        begin
                            // unused codes are consumed silently
                        end
                    endcase
                end
            end
            S_EMIT:
            begin
                // read data is valid; once free, send it and fetch any next entry
                if (rsp_free)
                begin
                    rsp_load                = 1'b1;
                    rsp_data_next.out_value = ram_rdata;
                    rsp_data_next.last      = (remain_reg == CNT_W'(1));
                    if (remain_reg != CNT_W'(1))
                    begin
                        ram_re      = 1'b1;
                        ram_raddr   = dptr_reg;
                        dptr_next   = dptr_inc;
                    end
                    remain_next = remain_reg - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Response register valid
    always_comb
    begin
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            remain_reg    <= '0;
            dptr_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            dptr_reg      <= dptr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

    // Emitting always has at least one entry left to send
    a_emit_remain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (remain_reg != '0))
        else $error("emit state with nothing left to send");

    // Sending the final entry returns the controller to idle
    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && rsp_free && remain_reg == CNT_W'(1)) |=>
        (state_reg == S_IDLE))
        else $error("controller did not return to idle after last beat");

    // A pop of a non-empty queue removes exactly one entry
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_accept && cmd_data.cmd == CMD_POP_FRONT && !is_empty) |=>
        (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not decrement the count");

    // A beat without last means the controller still has entries to send
    a_more_to_come: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_data.last) |-> (state_reg == S_EMIT))
        else $error("non-final beat while controller is idle");

    // Count never passes the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_accept |=> (count_reg <= CNT_W'(DEPTH)))
        else $error("entry count exceeds depth");

endmodule
